FILE: rtl/nimt_pkg.sv
// Shared types and codes for the lock-free inode match table.
// No dependencies; imported by every module of the block.
package nimt_pkg;

  // Field widths fixed by the item format
  localparam int unsigned DEV_W   = 64;
  localparam int unsigned INO_W   = 64;
  localparam int unsigned EXTID_W = 64;
  localparam int unsigned STAT_W  = 2;

  // Configuration port
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 5;

  // Register indexes (byte address is 8 * index)
  localparam logic [1:0] REG_ALL_FILES_FREE  = 2'd0;
  localparam logic [1:0] REG_ALL_DIRS_FREE   = 2'd1;
  localparam logic [1:0] REG_LOCK_FREE_EXTID = 2'd2;

  // Operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_LOOKUP_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INSERTED    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_PRESENT     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL        = 2'd3;

  // One stored pair
  typedef struct packed {
    logic [DEV_W-1:0] device;
    logic [INO_W-1:0] inode;
  } entry_t;

  // Configuration registers as seen by the match logic
  typedef struct packed {
    logic               all_files_free;
    logic               all_dirs_free;
    logic [EXTID_W-1:0] lock_free_extid;
  } cfg_t;

endpackage

FILE: rtl/nimt_table_mem.sv
// Entry store: synchronous memory of (device, inode) pairs, one write and one
// read port, read data registered. Depends on nimt_pkg.
module nimt_table_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  nimt_pkg::entry_t     wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output nimt_pkg::entry_t     rd_data
);
  import nimt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, read data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/nimt_regs.sv
// Configuration registers behind an APB-style port with 64-bit data.
// Depends on nimt_pkg for register indexes and the cfg_t bundle.
module nimt_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nimt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [nimt_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [nimt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output nimt_pkg::cfg_t                    cfg
);
  import nimt_pkg::*;

  logic               all_files_free_r;
  logic               all_dirs_free_r;
  logic [EXTID_W-1:0] lock_free_extid_r;
  logic               wr_stb;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_stb  = psel & penable & pwrite;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_files_free_r  <= 1'b0;
      all_dirs_free_r   <= 1'b0;
      lock_free_extid_r <= '0;
    end else if (wr_stb) begin
      case (reg_idx)
        REG_ALL_FILES_FREE:  all_files_free_r  <= pwdata[0];
        REG_ALL_DIRS_FREE:   all_dirs_free_r   <= pwdata[0];
        REG_LOCK_FREE_EXTID: lock_free_extid_r <= pwdata[EXTID_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (reg_idx)
      REG_ALL_FILES_FREE:  prdata = {{(CFG_DATA_W-1){1'b0}}, all_files_free_r};
      REG_ALL_DIRS_FREE:   prdata = {{(CFG_DATA_W-1){1'b0}}, all_dirs_free_r};
      REG_LOCK_FREE_EXTID: prdata = lock_free_extid_r;
      default:             prdata = '0;
    endcase
  end

  assign cfg.all_files_free  = all_files_free_r;
  assign cfg.all_dirs_free   = all_dirs_free_r;
  assign cfg.lock_free_extid = lock_free_extid_r;

endmodule

FILE: rtl/nolock_inode_match_table_top.sv
// Lock-free inode match table, top level: scan sequencer, output register.
// Depends on nimt_pkg, nimt_regs and nimt_table_mem.
//
// Usage
//   Input channel (in_*): one word per file, either a lookup or an insert.
//   Result channel (out_*): exactly one word per input word, in order.
//   Both channels use valid/stall; a word moves when valid is high and stall is
//   low. Configuration is written through the APB-style port (psel/penable/...)
//   at byte addresses 0, 8 and 16, by the user only while idle (not enforced).
// Timing
//   An item is taken one at a time. It is held while the stored entries
//   are read one per cycle from the entry memory (single read port, read
//   data registered), stopping at the first match. When a force flag
//   matches or the table is empty, the scan is skipped and the item goes
//   straight to the finish step.
// Reset
//   rst_n clears the registers, the entry count and the output valid; the
//   entry memory itself is not cleared, unwritten entries are never read.
// Stall
//   A finished result sits in the output register; a new item can be
//   scanned meanwhile, but its result waits until the old word is taken.
module nolock_inode_match_table_top #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic [nimt_pkg::DEV_W-1:0]        in_device,
  input  logic [nimt_pkg::INO_W-1:0]        in_inode,
  input  logic                              in_is_directory,
  input  logic [nimt_pkg::EXTID_W-1:0]      in_incoming_extid,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_lock_free,
  output logic [nimt_pkg::EXTID_W-1:0]      out_result_extid,
  output logic [nimt_pkg::STAT_W-1:0]       out_status,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nimt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [nimt_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [nimt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import nimt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  cfg_t cfg;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               hit_r, hit_nxt;
  logic               out_valid_r, out_valid_nxt;

  // held item
  logic               op_r;
  logic [DEV_W-1:0]   dev_r;
  logic [INO_W-1:0]   ino_r;
  logic [EXTID_W-1:0] inc_r;

  // output payload
  logic               out_lock_free_r;
  logic [EXTID_W-1:0] out_result_extid_r;
  logic [STAT_W-1:0]  out_status_r;

  logic               in_acc;
  logic               forced;
  logic               rd_en;
  logic               ent_match;
  logic               out_free;
  logic               mem_we;
  logic               do_load;
  entry_t             rd_data;
  entry_t             wr_data;

  nimt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nimt_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & (state_r == S_IDLE);
  assign forced   = cfg.all_files_free | (in_is_directory & cfg.all_dirs_free);

  // Scan: one read issued per cycle, compare the word read last cycle
  assign rd_en     = (state_r == S_SCAN) && (scan_idx_r < count_r);
  assign ent_match = rd_pend_r && (rd_data.inode == ino_r) &&
                     ((rd_data.device == '0) || (rd_data.device == dev_r));

  assign out_free = !out_valid_r || !out_stall;
  assign do_load  = (state_r == S_FINISH) && out_free;
  assign mem_we   = do_load && (op_r == OP_INSERT) && !hit_r && (count_r != FULL_CNT);
  assign wr_data.device = dev_r;
  assign wr_data.inode  = ino_r;

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_idx_nxt  = scan_idx_r;
    rd_pend_nxt   = 1'b0;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          hit_nxt      = forced;
          scan_idx_nxt = '0;
          state_nxt    = (forced || (count_r == '0)) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        rd_pend_nxt = rd_en;
        if (rd_en) begin
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end
        if (ent_match) begin
          hit_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else if (!rd_en) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (mem_we) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_idx_r  <= '0;
      rd_pend_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_idx_r  <= scan_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item capture and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_op;
      dev_r <= in_device;
      ino_r <= in_inode;
      inc_r <= in_incoming_extid;
    end
    if (do_load) begin
      out_lock_free_r <= hit_r;
      if (op_r == OP_LOOKUP) begin
        out_result_extid_r <= ((inc_r == '0) && hit_r) ? cfg.lock_free_extid : inc_r;
        out_status_r       <= STAT_LOOKUP_DONE;
      end else begin
        out_result_extid_r <= '0;
        if (hit_r) begin
          out_status_r <= STAT_PRESENT;
        end else if (count_r == FULL_CNT) begin
          out_status_r <= STAT_FULL;
        end else begin
          out_status_r <= STAT_INSERTED;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lock_free    = out_lock_free_r;
  assign out_result_extid = out_result_extid_r;
  assign out_status       = out_status_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count beyond table depth");

  a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (count_r < FULL_CNT) && !hit_r)
    else $error("entry written into full table or on a match");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("entry count did not advance after write");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result word raised outside finish step");

endmodule
